>>> rtl/dic_pkg.sv
// Shared types, constants and helper functions for the cascaded interrupt controller pair.
`default_nettype none

package dic_pkg;

    typedef enum logic [1:0] {
        ACT_BUS   = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STEP_IDLE = 2'd0,
        STEP_ICW2 = 2'd1,
        STEP_ICW3 = 2'd2,
        STEP_ICW4 = 2'd3
    } init_step_t;

    localparam logic [15:0] MASTER_PORT  = 16'h0020;
    localparam logic [15:0] SLAVE_PORT   = 16'h00A0;
    localparam logic [7:0]  MASTER_BASE  = 8'h08;
    localparam logic [7:0]  SLAVE_BASE   = 8'h70;
    localparam logic [7:0]  MASK_RESET   = 8'hFF;
    localparam logic [7:0]  BASE_MASK    = 8'hF8;
    localparam logic [7:0]  OCW3_READ_IS = 8'h0B;
    localparam logic [7:0]  OCW3_READ_RR = 8'h0A;
    localparam logic [7:0]  CASCADE_BIT  = 8'h04;
    localparam int unsigned CASCADE_LINE = 2;

    // Bit positions inside command bytes
    localparam int unsigned CMD_INIT_BIT = 4;
    localparam int unsigned CMD_EOI_BIT  = 5;
    localparam int unsigned CMD_SL_BIT   = 6;
    localparam int unsigned CMD_IC4_BIT  = 0;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // Per-chip update for one request
    typedef struct packed {
        logic       wr;
        logic       offset;
        logic [7:0] data;
        logic [7:0] req_set;
        logic [7:0] grant;
    } chip_op_t;

    typedef struct packed {
        logic [7:0] request;
        logic [7:0] in_service;
        logic [7:0] mask;
        logic [7:0] vec_base;
        logic       read_in_service;
    } chip_stat_t;

    typedef struct packed {
        logic [7:0] master_grant;
        logic [7:0] slave_grant;
        logic       valid;
        logic [7:0] vector;
    } ack_res_t;

    function automatic logic [7:0] lowest_onehot(input logic [7:0] v);
        lowest_onehot = v & (~v + 8'd1);
    endfunction

    function automatic logic [2:0] onehot_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                idx = idx | 3'(i);
            end
        end
        onehot_index = idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dual_interrupt_controller.sv
// Cascaded master/slave interrupt controller pair with stream request and result channels.
// Usage:
//   Each request on the s_ channel is a bus access to ports 0x20/0x21 (master) or
//   0xA0/0xA1 (slave), a raised interrupt line 0-15, or an acknowledge; s_tuser carries
//   the action code. Every request yields exactly one result on the m_ channel holding
//   handled, read_data, vector_valid and vector.
//   A request is captured in an input register, decoded and applied to the controller
//   state by short logic, and its result is loaded into the output register once that
//   register is empty or being emptied, which raises m_tvalid. One request per cycle is
//   sustained while the receiver keeps m_tready high.
//   A request sees the state left by every earlier request.
//   Reset (aresetn low, synchronous) empties both registers, clears request and
//   in-service bits, masks all lines and restores the vector bases 0x08 and 0x70.
//   When the receiver holds m_tready low, the result stays in the output register, one
//   more request waits in the input register, and s_tready then drops until the
//   result is taken.
`default_nettype none

module dual_interrupt_controller
    import dic_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [15:0] port, [16] is_read, [24:17] write_data, [32:25] irq_line, rest zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] handled, [8:1] read_data, [9] vector_valid, [17:10] vector, rest zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic        in_valid_reg;
    action_t     action_reg;
    logic [15:0] port_reg;
    logic        is_read_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  line_reg;

    logic        out_valid_reg;
    logic        handled_reg, handled_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic        vvalid_reg;
    logic [7:0]  vector_reg;

    logic        advance;
    logic        m_hit, s_hit;
    logic [7:0]  m_raise, s_raise;
    chip_op_t    m_op, s_op;
    chip_stat_t  m_stat, s_stat;
    ack_res_t    ack_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            action_reg  <= action_t'(s_tuser);
            port_reg    <= s_tdata[15:0];
            is_read_reg <= s_tdata[16];
            wdata_reg   <= s_tdata[24:17];
            line_reg    <= s_tdata[32:25];
        end
    end

    // decode
    always_comb begin
        m_hit   = (action_reg == ACT_BUS) && (port_reg[15:1] == MASTER_PORT[15:1]);
        s_hit   = (action_reg == ACT_BUS) && (port_reg[15:1] == SLAVE_PORT[15:1]);
        m_raise = 8'h00;
        s_raise = 8'h00;
        if (action_reg == ACT_RAISE) begin
            if (line_reg[7:3] == 5'd0) begin
                m_raise = 8'd1 << line_reg[2:0];
            end else if (line_reg[7:3] == 5'd1) begin
                s_raise = 8'd1 << line_reg[2:0];
                m_raise = CASCADE_BIT;
            end
        end

        m_op.wr      = m_hit && !is_read_reg;
        m_op.offset  = port_reg[0];
        m_op.data    = wdata_reg;
        m_op.req_set = m_raise;
        m_op.grant   = ack_res.master_grant;

        s_op.wr      = s_hit && !is_read_reg;
        s_op.offset  = port_reg[0];
        s_op.data    = wdata_reg;
        s_op.req_set = s_raise;
        s_op.grant   = ack_res.slave_grant;
    end

    dic_chip #(
        .RESET_BASE (MASTER_BASE)
    ) u_master (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .op      (m_op),
        .stat    (m_stat)
    );

    dic_chip #(
        .RESET_BASE (SLAVE_BASE)
    ) u_slave (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .op      (s_op),
        .stat    (s_stat)
    );

    dic_ack u_ack (
        .ack (action_reg == ACT_ACK),
        .mst (m_stat),
        .slv (s_stat),
        .res (ack_res)
    );

    // read path
    always_comb begin
        handled_next = m_hit || s_hit;
        rdata_next   = 8'h00;
        if ((m_hit || s_hit) && is_read_reg) begin
            priority if (m_hit && !port_reg[0]) begin
                rdata_next = m_stat.read_in_service ? m_stat.in_service : m_stat.request;
            end else if (m_hit) begin
                rdata_next = m_stat.mask;
            end else if (!port_reg[0]) begin
                rdata_next = s_stat.read_in_service ? s_stat.in_service : s_stat.request;
            end else begin
                rdata_next = s_stat.mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            handled_reg <= handled_next;
            rdata_reg   <= rdata_next;
            vvalid_reg  <= ack_res.valid;
            vector_reg  <= ack_res.vector;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, vector_reg, vvalid_reg, rdata_reg, handled_reg};

`ifndef SYNTH
    // a bus access never produces a vector, an acknowledge never hits a port
    a_excl_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("handled and vector_valid both set");

    // a slave grant always marks the cascade line in service on the master
    a_cascade_isr: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (|ack_res.slave_grant)) |=> m_stat.in_service[CASCADE_LINE])
        else $error("slave grant without master cascade in-service");

    a_grant_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ack_res.master_grant) && $onehot0(ack_res.slave_grant))
        else $error("more than one grant bit");

    // input side stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

>>> rtl/dic_chip.sv
// State and register-access logic of one 8259-style interrupt controller.
`default_nettype none

module dic_chip
    import dic_pkg::*;
#(
    parameter logic [7:0] RESET_BASE = 8'h08
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire chip_op_t   op,
    output chip_stat_t      stat
);

    logic [7:0] request_reg, request_next;
    logic [7:0] in_service_reg, in_service_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] base_reg, base_next;
    init_step_t step_reg, step_next;
    logic       icw4_reg, icw4_next;
    logic       ris_reg, ris_next;
    logic [7:0] d;

    assign d = op.data;

    always_comb begin
        request_next    = request_reg;
        in_service_next = in_service_reg;
        mask_next       = mask_reg;
        base_next       = base_reg;
        step_next       = step_reg;
        icw4_next       = icw4_reg;
        ris_next        = ris_reg;

        if (op.wr) begin
            if (!op.offset) begin
                priority if (d[CMD_INIT_BIT]) begin
                    step_next       = STEP_ICW2;
                    icw4_next       = d[CMD_IC4_BIT];
                    mask_next       = 8'h00;
                    in_service_next = 8'h00;
                    request_next    = 8'h00;
                end else if (d[CMD_SL_BIT] && d[CMD_EOI_BIT]) begin
                    in_service_next = in_service_reg & ~(8'd1 << d[2:0]);
                end else if (d[CMD_EOI_BIT]) begin
                    // non-specific EOI drops the highest-priority in-service bit
                    in_service_next = in_service_reg & ~lowest_onehot(in_service_reg);
                end else if (d == OCW3_READ_IS) begin
                    ris_next = 1'b1;
                end else if (d == OCW3_READ_RR) begin
                    ris_next = 1'b0;
                end else if (d[CMD_SL_BIT]) begin
                    in_service_next = in_service_reg & ~(8'd1 << d[2:0]);
                end
            end else begin
                unique case (step_reg)
                    STEP_ICW2: begin
                        base_next = d & BASE_MASK;
                        step_next = STEP_ICW3;
                    end
                    STEP_ICW3: begin
                        step_next = icw4_reg ? STEP_ICW4 : STEP_IDLE;
                    end
                    STEP_ICW4: begin
                        step_next = STEP_IDLE;
                    end
                    default: begin
                        mask_next = d;
                    end
                endcase
            end
        end

        request_next    = (request_next | op.req_set) & ~op.grant;
        in_service_next = in_service_next | op.grant;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_reg    <= 8'h00;
            in_service_reg <= 8'h00;
            mask_reg       <= MASK_RESET;
            base_reg       <= RESET_BASE;
            step_reg       <= STEP_IDLE;
            icw4_reg       <= 1'b0;
            ris_reg        <= 1'b0;
        end else if (en) begin
            request_reg    <= request_next;
            in_service_reg <= in_service_next;
            mask_reg       <= mask_next;
            base_reg       <= base_next;
            step_reg       <= step_next;
            icw4_reg       <= icw4_next;
            ris_reg        <= ris_next;
        end
    end

    assign stat.request         = request_reg;
    assign stat.in_service      = in_service_reg;
    assign stat.mask            = mask_reg;
    assign stat.vec_base        = base_reg;
    assign stat.read_in_service = ris_reg;

endmodule

`default_nettype wire

>>> rtl/dic_ack.sv
// Acknowledge resolution: priority pick across master and cascaded slave, vector build.
`default_nettype none

module dic_ack
    import dic_pkg::*;
(
    input  wire logic       ack,
    input  wire chip_stat_t mst,
    input  wire chip_stat_t slv,
    output ack_res_t        res
);

    logic [7:0] m_pend, s_pend, m_elig, m_pick, s_pick;
    logic       s_ok;

    always_comb begin
        m_pend = mst.request & ~mst.mask & ~mst.in_service;
        s_pend = slv.request & ~slv.mask & ~slv.in_service;
        s_ok   = |s_pend;
        // cascade line only counts when the slave has something to give
        m_elig = s_ok ? m_pend : (m_pend & ~CASCADE_BIT);
        m_pick = lowest_onehot(m_elig);
        s_pick = lowest_onehot(s_pend);

        res = '0;
        if (ack && (|m_pick)) begin
            res.valid        = 1'b1;
            res.master_grant = m_pick;
            if (m_pick[CASCADE_LINE]) begin
                res.slave_grant = s_pick;
                res.vector      = slv.vec_base + {5'd0, onehot_index(s_pick)};
            end else begin
                res.vector      = mst.vec_base + {5'd0, onehot_index(m_pick)};
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/dual_interrupt_controller_test.sv
// Self-checking stream testbench for the cascaded master/slave interrupt controller pair.
`timescale 1ns / 1ps

module dual_interrupt_controller_test;
    import dic_pkg::*;

    localparam int N_DIRECTED     = 26;
    localparam int N_RANDOM       = 1675;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [15:0] M_CMD  = MASTER_PORT;
    localparam logic [15:0] M_DATA = MASTER_PORT | 16'h0001;
    localparam logic [15:0] S_CMD  = SLAVE_PORT;
    localparam logic [15:0] S_DATA = SLAVE_PORT | 16'h0001;

    localparam logic [7:0] CMD_INIT     = 8'h10;
    localparam logic [7:0] CMD_EOI      = 8'h20;
    localparam logic [7:0] CMD_LEVEL    = 8'h40;
    localparam logic [7:0] CMD_SPEC_EOI = 8'h60;

    typedef struct packed {
        action_t     action;
        logic [15:0] port;
        logic        is_read;
        logic [7:0]  wdata;
        logic [7:0]  line;
    } req_t;

    typedef struct packed {
        logic       handled;
        logic [7:0] rdata;
        logic       vec_valid;
        logic [7:0] vector;
    } resp_t;

    typedef struct packed {
        req_t  req;
        logic  typed;
        resp_t want;
    } dir_row_t;

    typedef struct {
        logic [7:0] request;
        logic [7:0] in_service;
        logic [7:0] mask;
        logic [7:0] vec_base;
        init_step_t step;
        logic       expect_icw4;
        logic       isr_select;
    } pic_state_t;

    // columns: action, port, is_read, write_data, irq_line | typed, handled, read_data,
    // vector_valid, vector
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // reset values: request, masks, nothing deliverable; then line 3 raised, unmasked, acked
        {ACT_BUS,   M_CMD,      1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_DATA,     1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0, 8'h00},
        {ACT_ACK,   16'h0000,   1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_RAISE, 16'h0000,   1'b0, 8'h00, 8'd3,  1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_CMD,      1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 8'h08, 1'b0, 8'h00},
        {ACT_BUS,   M_DATA,     1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00},
        {ACT_ACK,   16'h0000,   1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 8'h0B},
        // ignored line, unmatched port, unused action code
        {ACT_RAISE, 16'h0000,   1'b0, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   16'hFFFF,   1'b1, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_NONE,  16'hFFFF,   1'b1, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        // slave line while slave is masked: search must skip over the cascade line
        {ACT_RAISE, 16'h0000,   1'b0, 8'h00, 8'd9,  1'b1, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_ACK,   16'h0000,   1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00},
        {ACT_ACK,   16'h0000,   1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        // in-service readback and the three end-of-interrupt flavors
        {ACT_BUS,   M_CMD, 1'b0, OCW3_READ_IS, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_CMD,      1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_CMD,      1'b0, CMD_EOI, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_CMD, 1'b0, CMD_SPEC_EOI | 8'h03, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_CMD, 1'b0, CMD_LEVEL | 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        // full slave init with ICW4, top vector base
        {ACT_BUS,   S_CMD, 1'b0, CMD_INIT | 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b0, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b0, 8'h02, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b0, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   S_DATA,     1'b1, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00},
        {ACT_BUS,   M_CMD, 1'b0, OCW3_READ_RR, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    pic_state_t master_pic;
    pic_state_t slave_pic;
    resp_t      pending_responses [$];
    req_t       plan [$];
    resp_t      seen_resp;
    resp_t      oldest_resp;

    int err_cnt      = 0;
    int stall_cycles = 0;
    int burst_left   = 0;
    int rx_left      = 0;
    int rx_mode      = 0;
    int n_requests   = 0;
    int n_bus_hits   = 0;
    int n_vectors    = 0;
    int n_drains     = 0;

    dual_interrupt_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic int lowest_set(input logic [7:0] v);
        int idx;
        idx = 8;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) idx = i;
        end
        return idx;
    endfunction

    function automatic bit pic_port_hit(input logic [15:0] port);
        return port[15:1] == MASTER_PORT[15:1] || port[15:1] == SLAVE_PORT[15:1];
    endfunction

    function automatic pic_state_t pic_reset(input logic [7:0] base);
        pic_state_t c;
        c.request     = '0;
        c.in_service  = '0;
        c.mask        = MASK_RESET;
        c.vec_base    = base;
        c.step        = STEP_IDLE;
        c.expect_icw4 = 1'b0;
        c.isr_select  = 1'b0;
        return c;
    endfunction

    function automatic pic_state_t pic_apply_write(input pic_state_t c, input logic offset,
                                                   input logic [7:0] d);
        pic_state_t n;
        int b;
        n = c;
        if (!offset) begin
            // priority order of the command decode matters
            if (d[CMD_INIT_BIT]) begin
                n.step        = STEP_ICW2;
                n.expect_icw4 = d[CMD_IC4_BIT];
                n.mask        = '0;
                n.in_service  = '0;
                n.request     = '0;
            end else if (d[CMD_SL_BIT] && d[CMD_EOI_BIT]) begin
                n.in_service[d[2:0]] = 1'b0;
            end else if (d[CMD_EOI_BIT]) begin
                b = lowest_set(c.in_service);
                if (b < 8) n.in_service[b] = 1'b0;
            end else if (d == OCW3_READ_IS) begin
                n.isr_select = 1'b1;
            end else if (d == OCW3_READ_RR) begin
                n.isr_select = 1'b0;
            end else if (d[CMD_SL_BIT]) begin
                n.in_service[d[2:0]] = 1'b0;
            end
        end else begin
            case (c.step)
                STEP_ICW2: begin
                    n.vec_base = d & BASE_MASK;
                    n.step     = STEP_ICW3;
                end
                STEP_ICW3: n.step = c.expect_icw4 ? STEP_ICW4 : STEP_IDLE;
                STEP_ICW4: n.step = STEP_IDLE;
                default:   n.mask = d;
            endcase
        end
        return n;
    endfunction

    // Applies one request to the predicted controller state and returns its result.
    function automatic resp_t pic_pair_response(input req_t r);
        resp_t      o;
        pic_state_t sel;
        logic [7:0] m;
        logic [7:0] s;
        logic       hit;
        logic       to_slave;
        int         j;
        o = '0;
        case (r.action)
            ACT_BUS: begin
                if (pic_port_hit(r.port)) begin
                    to_slave  = r.port[15:1] == SLAVE_PORT[15:1];
                    o.handled = 1'b1;
                    sel = to_slave ? slave_pic : master_pic;
                    if (r.is_read) begin
                        o.rdata = r.port[0] ? sel.mask
                                : (sel.isr_select ? sel.in_service : sel.request);
                    end else if (to_slave) begin
                        slave_pic = pic_apply_write(slave_pic, r.port[0], r.wdata);
                    end else begin
                        master_pic = pic_apply_write(master_pic, r.port[0], r.wdata);
                    end
                end
            end
            ACT_RAISE: begin
                if (r.line < 8) begin
                    master_pic.request[r.line[2:0]] = 1'b1;
                end else if (r.line < 16) begin
                    slave_pic.request[r.line[2:0]] = 1'b1;
                    master_pic.request |= CASCADE_BIT;
                end
            end
            ACT_ACK: begin
                m   = master_pic.request & ~master_pic.mask & ~master_pic.in_service;
                hit = 1'b0;
                for (int i = 0; i < 8; i++) begin
                    if (!hit && m[i]) begin
                        if (i == CASCADE_LINE) begin
                            // empty slave: fall through to the next master line
                            s = slave_pic.request & ~slave_pic.mask & ~slave_pic.in_service;
                            j = lowest_set(s);
                            if (j < 8) begin
                                slave_pic.request[j]    = 1'b0;
                                slave_pic.in_service[j] = 1'b1;
                                master_pic.request     &= ~CASCADE_BIT;
                                master_pic.in_service  |= CASCADE_BIT;
                                o.vector = slave_pic.vec_base + 8'(j);
                                hit      = 1'b1;
                            end
                        end else begin
                            master_pic.request[i]    = 1'b0;
                            master_pic.in_service[i] = 1'b1;
                            o.vector = master_pic.vec_base + 8'(i);
                            hit      = 1'b1;
                        end
                    end
                end
                o.vec_valid = hit;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic bit is_ignored(input req_t r);
        case (r.action)
            ACT_BUS:   return !pic_port_hit(r.port);
            ACT_RAISE: return r.line >= 16;
            ACT_ACK:   return 1'b0;
            default:   return 1'b1;
        endcase
    endfunction

    function automatic req_t bus_req(input logic [15:0] port, input logic rd,
                                     input logic [7:0] d);
        req_t r;
        r.action  = ACT_BUS;
        r.port    = port;
        r.is_read = rd;
        r.wdata   = d;
        r.line    = 8'($urandom);
        return r;
    endfunction

    function automatic req_t line_req(input action_t a, input logic [7:0] line);
        req_t r;
        r.action  = a;
        r.port    = 16'($urandom);
        r.is_read = 1'($urandom);
        r.wdata   = 8'($urandom);
        r.line    = line;
        return r;
    endfunction

    // Queues one short, mostly well-formed sequence of requests.
    task automatic plan_sequence();
        logic [15:0] cmd_port;
        logic [7:0]  d;
        req_t        r;
        int          kind;
        int          n;
        cmd_port = $urandom_range(0, 1) ? S_CMD : M_CMD;
        kind     = $urandom_range(0, 99);
        if (kind < 8) begin
            d = 8'($urandom) | CMD_INIT;
            plan.push_back(bus_req(cmd_port, 1'b0, d));
            n = d[CMD_IC4_BIT] ? 3 : 2;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n - 1);  // cut short
            for (int k = 0; k < n; k++) begin
                plan.push_back(bus_req(cmd_port | 16'h0001, 1'b0, 8'($urandom)));
            end
        end else if (kind < 20) begin
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom & $urandom & $urandom);
            plan.push_back(bus_req(cmd_port | 16'h0001, 1'b0, d));
        end else if (kind < 45) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                plan.push_back(line_req(ACT_RAISE, 8'($urandom_range(0, 15))));
            end
        end else if (kind < 64) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) plan.push_back(line_req(ACT_ACK, 8'($urandom)));
        end else if (kind < 77) begin
            case ($urandom_range(0, 3))
                0:       d = CMD_EOI | (8'($urandom) & 8'h8F);
                1:       d = CMD_SPEC_EOI | (8'($urandom) & 8'h8F);
                2:       d = CMD_LEVEL | (8'($urandom) & 8'h8F);
                default: d = 8'($urandom) & 8'h8F;
            endcase
            plan.push_back(bus_req(cmd_port, 1'b0, d));
        end else if (kind < 88) begin
            if ($urandom_range(0, 1)) begin
                d = $urandom_range(0, 1) ? OCW3_READ_IS : OCW3_READ_RR;
                plan.push_back(bus_req(cmd_port, 1'b0, d));
            end
            plan.push_back(bus_req(cmd_port | 16'($urandom_range(0, 1)), 1'b1, 8'($urandom)));
        end else begin
            r = line_req(action_t'($urandom_range(0, 3)), 8'($urandom));
            if ($urandom_range(0, 1)) r.port = cmd_port ^ (16'd1 << $urandom_range(1, 15));
            plan.push_back(r);
        end
    endtask

    // Presents one request, waits for its handshake and records the expected result.
    task automatic issue(input req_t r, input bit typed, input resp_t typed_resp);
        resp_t predicted;
        s_tuser  <= r.action;
        s_tdata  <= {7'd0, r.line, r.wdata, r.is_read, r.port};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = pic_pair_response(r);
        pending_responses.push_back(typed ? typed_resp : predicted);
        n_requests++;
        if (predicted.handled) n_bus_hits++;
        if (predicted.vec_valid) n_vectors++;
    endtask

    // Sender pacing: bursts with random gaps, or a full drain of outstanding results.
    task automatic pace(input bit drain);
        if (drain || burst_left == 0) begin
            s_tvalid <= 1'b0;
            if (drain) begin
                n_drains++;
                do @(posedge aclk); while (pending_responses.size() != 0);
            end else begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                    : $urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: phases of always-ready, coin-flip, and heavy stalling
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_resp = {m_tdata[0], m_tdata[8:1], m_tdata[9], m_tdata[17:10]};
            if (pending_responses.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("ERROR: result %h with none expected at %0t",
                                            m_tdata, $realtime);
            end else begin
                oldest_resp = pending_responses.pop_front();
                if (seen_resp.handled !== oldest_resp.handled ||
                    seen_resp.rdata !== oldest_resp.rdata ||
                    seen_resp.vec_valid !== oldest_resp.vec_valid ||
                    seen_resp.vector !== oldest_resp.vector) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("ERROR at %0t: expected handled=%0d read_data=%h valid=%0d %s",
                                 $realtime, oldest_resp.handled, oldest_resp.rdata,
                                 oldest_resp.vec_valid, $sformatf("vector=%h", oldest_resp.vector));
                        $display("       got      handled=%0d read_data=%h valid=%0d vector=%h",
                                 seen_resp.handled, seen_resp.rdata, seen_resp.vec_valid,
                                 seen_resp.vector);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        req_t r;
        int   useful;
        master_pic = pic_reset(MASTER_BASE);
        slave_pic  = pic_reset(SLAVE_BASE);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            issue(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want);
            pace(k == N_DIRECTED - 1);
        end

        useful = 0;
        while (useful < N_RANDOM) begin
            if (plan.size() == 0) plan_sequence();
            r = plan.pop_front();
            issue(r, 1'b0, '0);
            if (!is_ignored(r)) useful++;
            pace(!is_ignored(r) && useful % 500 == 0);
        end
        s_tvalid <= 1'b0;

        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d requests (%0d directed): %0d controller port accesses, %0d vectors",
                 n_requests, N_DIRECTED, n_bus_hits, n_vectors);
        $display("Full drains of the result stream: %0d; mismatching results: %0d",
                 n_drains, err_cnt);
        if (err_cnt == 0 && pending_responses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> dual_interrupt_controller.f
rtl/dic_pkg.sv
rtl/dic_chip.sv
rtl/dic_ack.sv
rtl/dual_interrupt_controller.sv
tb/sv/dual_interrupt_controller_test.sv
